FILE: rtl/ssms_pkg.sv
package ssms_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_W     = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_HOLD = 2'd2
  } servo_mode_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_SERVO_WAIT = 3'd1,
    REG_SERVO_HOLD = 3'd2,
    REG_MOTOR_STOP = 3'd3,
    REG_PAUSE      = 3'd4,
    REG_PROX_POL   = 3'd5
  } reg_idx_t;

  localparam logic [7:0] CMD_PAUSE  = 8'hA5;
  localparam logic [6:0] ANGLE_UP   = 7'd90;
  localparam logic [6:0] ANGLE_DOWN = 7'd0;

  localparam cfg_word_t RST_DEBOUNCE   = 16'd30;
  localparam cfg_word_t RST_SERVO_WAIT = 16'd1000;
  localparam cfg_word_t RST_SERVO_HOLD = 16'd1000;
  localparam cfg_word_t RST_MOTOR_STOP = 16'd3000;
  localparam cfg_word_t RST_PAUSE      = 16'd5000;

  typedef struct packed {
    cfg_word_t debounce_ms;
    cfg_word_t swing_delay_ms;
    cfg_word_t swing_hold_ms;
    cfg_word_t motor_stop_ms;
    cfg_word_t pause_ms;
    logic      prox_invert;
  } cfg_t;

  typedef struct packed {
    logic       prox_raw;
    logic [7:0] command;
  } item_t;

  typedef struct packed {
    logic [6:0] servo_angle;
    logic       motor_on;
    logic       paused;
    logic [7:0] box_count;
    logic [1:0] servo_phase;
  } result_t;

  function automatic time_t ext16(input cfg_word_t v);
    return {{(TIME_BITS-CFG_W){1'b0}}, v};
  endfunction

  // deadline reached when the wrapped difference sits in the lower half
  function automatic logic reached(input time_t now, input time_t deadline);
    time_t diff;
    diff = now - deadline;
    return ~diff[TIME_BITS-1];
  endfunction

  function automatic logic elapsed(input time_t now, input time_t start,
                                   input cfg_word_t span);
    time_t diff;
    diff = now - start;
    return (diff >= ext16(span));
  endfunction

endpackage

FILE: rtl/ssms_in_if.sv
interface ssms_in_if;
  import ssms_pkg::*;

  logic       valid;
  logic       ready;
  logic       prox_raw;
  logic [7:0] command;

  modport source (output valid, output prox_raw, output command, input ready);
  modport sink   (input valid, input prox_raw, input command, output ready);
endinterface

FILE: rtl/ssms_out_if.sv
interface ssms_out_if;
  import ssms_pkg::*;

  logic       valid;
  logic       ready;
  logic [6:0] servo_angle;
  logic       motor_on;
  logic       paused;
  logic [7:0] box_count;
  logic [1:0] servo_phase;

  modport source (output valid, output servo_angle, output motor_on, output paused,
                  output box_count, output servo_phase, input ready);
  modport sink   (input valid, input servo_angle, input motor_on, input paused,
                  input box_count, input servo_phase, output ready);
endinterface

FILE: rtl/ssms_cfg.sv
module ssms_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssms_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssms_pkg::DATA_W-1:0]  pwdata,
  output logic [ssms_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ssms_pkg::cfg_t               cfg
);
  import ssms_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= RST_DEBOUNCE;
      cfg_r.swing_delay_ms <= RST_SERVO_WAIT;
      cfg_r.swing_hold_ms  <= RST_SERVO_HOLD;
      cfg_r.motor_stop_ms  <= RST_MOTOR_STOP;
      cfg_r.pause_ms       <= RST_PAUSE;
      cfg_r.prox_invert    <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_DEBOUNCE:   cfg_r.debounce_ms    <= pwdata[CFG_W-1:0];
        REG_SERVO_WAIT: cfg_r.swing_delay_ms <= pwdata[CFG_W-1:0];
        REG_SERVO_HOLD: cfg_r.swing_hold_ms  <= pwdata[CFG_W-1:0];
        REG_MOTOR_STOP: cfg_r.motor_stop_ms  <= pwdata[CFG_W-1:0];
        REG_PAUSE:      cfg_r.pause_ms       <= pwdata[CFG_W-1:0];
        REG_PROX_POL:   cfg_r.prox_invert    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DEBOUNCE:   prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_r.debounce_ms};
      REG_SERVO_WAIT: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_r.swing_delay_ms};
      REG_SERVO_HOLD: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_r.swing_hold_ms};
      REG_MOTOR_STOP: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_r.motor_stop_ms};
      REG_PAUSE:      prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_r.pause_ms};
      REG_PROX_POL:   prdata = {{(DATA_W-1){1'b0}}, cfg_r.prox_invert};
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ssms_core.sv
module ssms_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ssms_pkg::item_t   item,
  input  ssms_pkg::cfg_t    cfg,
  output ssms_pkg::result_t result
);
  import ssms_pkg::*;

  // tick_r holds the time the next tick will work at
  time_t       tick_r, tick_nxt;
  logic        stable_r, stable_nxt;
  logic        last_raw_r, last_raw_nxt;
  time_t       last_chg_r, last_chg_nxt;
  servo_mode_t mode_r, mode_nxt;
  time_t       servo_dl_r, servo_dl_nxt;
  logic        at_ninety_r, at_ninety_nxt;
  logic [7:0]  boxes_r, boxes_nxt;
  logic        motor_r, motor_nxt;
  time_t       resume_r, resume_nxt;
  logic        pause_r, pause_nxt;
  time_t       pause_end_r, pause_end_nxt;

  logic  sample;
  logic  accepted;
  time_t now;

  always_comb begin
    sample        = item.prox_raw ^ cfg.prox_invert;
    now           = tick_r;
    tick_nxt      = tick_r + time_t'(1);
    stable_nxt    = stable_r;
    last_raw_nxt  = last_raw_r;
    last_chg_nxt  = last_chg_r;
    mode_nxt      = mode_r;
    servo_dl_nxt  = servo_dl_r;
    at_ninety_nxt = at_ninety_r;
    boxes_nxt     = boxes_r;
    motor_nxt     = motor_r;
    resume_nxt    = resume_r;
    pause_nxt     = pause_r;
    pause_end_nxt = pause_end_r;
    accepted      = 1'b0;

    if (item.command == CMD_PAUSE) begin
      if (mode_r != MODE_IDLE) begin
        servo_dl_nxt = servo_dl_r + ext16(cfg.pause_ms);
      end
      if (motor_r || reached(now, resume_r)) begin
        resume_nxt = now + ext16(cfg.pause_ms);
      end else begin
        resume_nxt = resume_r + ext16(cfg.pause_ms);
      end
      motor_nxt     = 1'b0;
      pause_nxt     = 1'b1;
      pause_end_nxt = now + ext16(cfg.pause_ms);
    end
    if (pause_nxt && reached(now, pause_end_nxt)) begin
      pause_nxt = 1'b0;
    end

    if (!pause_nxt) begin
      if (sample != last_raw_r) begin
        last_raw_nxt = sample;
        last_chg_nxt = now;
      end
      if ((sample != stable_r) && elapsed(now, last_chg_nxt, cfg.debounce_ms)) begin
        stable_nxt = sample;
        accepted   = 1'b1;
      end
      if (accepted && stable_nxt && (mode_nxt == MODE_IDLE)) begin
        mode_nxt     = MODE_WAIT;
        servo_dl_nxt = now + ext16(cfg.swing_delay_ms);
      end

      if ((mode_nxt == MODE_WAIT) && reached(now, servo_dl_nxt)) begin
        motor_nxt     = 1'b0;
        resume_nxt    = now + ext16(cfg.motor_stop_ms);
        if (!at_ninety_nxt) begin
          boxes_nxt = boxes_r + 8'd1;
        end
        at_ninety_nxt = 1'b1;
        mode_nxt      = MODE_HOLD;
        servo_dl_nxt  = now + ext16(cfg.swing_hold_ms);
      end else if ((mode_nxt == MODE_HOLD) && reached(now, servo_dl_nxt)) begin
        at_ninety_nxt = 1'b0;
        mode_nxt      = MODE_IDLE;
      end

      if (!motor_nxt && reached(now, resume_nxt)) begin
        motor_nxt = 1'b1;
      end
    end

    result.servo_angle = at_ninety_nxt ? ANGLE_UP : ANGLE_DOWN;
    result.motor_on    = motor_nxt;
    result.paused      = pause_nxt;
    result.box_count   = boxes_nxt;
    result.servo_phase = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= time_t'(1);
      stable_r    <= 1'b0;
      last_raw_r  <= 1'b0;
      last_chg_r  <= '0;
      mode_r      <= MODE_IDLE;
      servo_dl_r  <= '0;
      at_ninety_r <= 1'b0;
      boxes_r     <= '0;
      motor_r     <= 1'b1;
      resume_r    <= '0;
      pause_r     <= 1'b0;
      pause_end_r <= '0;
    end else if (step) begin
      tick_r      <= tick_nxt;
      stable_r    <= stable_nxt;
      last_raw_r  <= last_raw_nxt;
      last_chg_r  <= last_chg_nxt;
      mode_r      <= mode_nxt;
      servo_dl_r  <= servo_dl_nxt;
      at_ninety_r <= at_ninety_nxt;
      boxes_r     <= boxes_nxt;
      motor_r     <= motor_nxt;
      resume_r    <= resume_nxt;
      pause_r     <= pause_nxt;
      pause_end_r <= pause_end_nxt;
    end
  end

endmodule

FILE: rtl/sorter_servo_motor_sequencer_top.sv
// Sorter servo and conveyor sequencer.
// in_if carries one transaction per millisecond tick: the raw proximity
// pin level and the received command byte (0xA5 starts a system pause).
// out_if returns exactly one transaction per input transaction, in order:
// servo angle (0 or 90), motor drive, pause flag, box count, servo phase.
// Timing registers are written over the APB port (psel..pready, byte
// address 4*index, pready tied high); the user must write them only
// while the block is idle, as the block itself does not enforce it.
// An accepted input waits in the input register; the state update and
// result register load follow, after which out_if.valid is high.
// Throughput: one transaction per cycle when not stalled; a tick is a
// single pass of compares and 32-bit adds, input to result register.
// Receiver stall: the result register holds its transaction; the input
// register still takes one more transaction, then in_if.ready drops until
// the result is taken. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous): registers return to their power-on
// values, tick time to one, motor running, servo idle, no pause, both
// channel stages empty.
module sorter_servo_motor_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  ssms_in_if.sink                     in_if,
  ssms_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssms_pkg::ADDR_W-1:0] paddr,
  input  logic [ssms_pkg::DATA_W-1:0] pwdata,
  output logic [ssms_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ssms_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_valid_r;
  logic    step;

  // tick is processed once the result register is free or being drained
  assign step        = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r.prox_raw <= in_if.prox_raw;
      in_item_r.command  <= in_if.command;
    end
  end

  ssms_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssms_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.servo_angle = out_res_r.servo_angle;
  assign out_if.motor_on    = out_res_r.motor_on;
  assign out_if.paused      = out_res_r.paused;
  assign out_if.box_count   = out_res_r.box_count;
  assign out_if.servo_phase = out_res_r.servo_phase;

endmodule

FILE: rtl/ssms_checker.sv
module ssms_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] servo_angle,
  input logic       motor_on,
  input logic       paused,
  input logic [7:0] box_count,
  input logic [1:0] servo_phase
);
  import ssms_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(servo_angle) && $stable(motor_on)
      && $stable(paused) && $stable(box_count) && $stable(servo_phase))
    else $error("stalled result changed");

  // servo sits at ninety exactly while holding
  a_angle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((servo_angle == ANGLE_UP) == (servo_phase == MODE_HOLD))
      && (servo_angle == ANGLE_UP || servo_angle == ANGLE_DOWN))
    else $error("servo angle and phase disagree");

  // a pause always stops the conveyor
  a_pause_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && paused |-> !motor_on)
    else $error("motor driven during pause");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorter_servo_motor_sequencer_top ssms_port_checker u_ssms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .servo_angle (out_if.servo_angle),
  .motor_on    (out_if.motor_on),
  .paused      (out_if.paused),
  .box_count   (out_if.box_count),
  .servo_phase (out_if.servo_phase)
);
